>>> src/csvg_pkg.sv
// Shared types, constants and helpers of the cone segment vertex generator.
`default_nettype none
package csvg_pkg;

	localparam int unsigned MAX_SEGMENTS_DEF = 4096;
	localparam int unsigned ANGLE_BITS_DEF   = 16;

	localparam int unsigned CNT_W    = 13;
	localparam int unsigned IDX_W    = 12;
	localparam int unsigned VIDX_W   = 14;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DAT_W = 16;
	localparam int unsigned QDEPTH   = 2;

	// serial divider and root widths
	localparam int unsigned DVD_W = 48;
	localparam int unsigned DVS_W = 32;
	localparam int unsigned SQ_W  = 61;

	localparam logic [CFG_IDX_W-1:0] CFG_SEGMENT_COUNT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CONE_HEIGHT   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BOTTOM_RADIUS = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_TOP_RADIUS    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_OFFSET  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_FLIP_NORMALS  = 3'd5;

	localparam logic signed [31:0] SIN_C1 = 32'sd421657428;
	localparam logic signed [31:0] SIN_C3 = -32'sd173399667;
	localparam logic signed [31:0] SIN_C5 = 32'sd21392326;
	localparam logic signed [31:0] SIN_C7 = -32'sd1256749;
	localparam logic signed [31:0] SIN_C9 = 32'sd43068;

	localparam logic [DVD_W-1:0] SLOPE_LIMIT = DVD_W'(64'd1073741824);
	localparam logic [DVD_W-1:0] UNIT_ONE    = DVD_W'(64'd16384);

	typedef enum logic [2:0] {
		DIV_A0, DIV_A1, DIV_AH, DIV_SLOPE, DIV_NX, DIV_NY, DIV_NZ
	} div_op_t;

	typedef enum logic [3:0] {
		BS_IDLE, BS_DSTART, BS_DWAIT, BS_SPROD, BS_TSETUP, BS_TSQ, BS_TX2,
		BS_THMUL, BS_THADD, BS_TFMUL, BS_TFIN, BS_SQMUL, BS_SQACC, BS_SQRT, BS_HAND
	} back_state_t;

	typedef struct packed {
		logic [IDX_W-1:0] seg;
		logic signed [15:0] c0x;
		logic signed [15:0] c0y;
		logic signed [15:0] c1x;
		logic signed [15:0] c1y;
		logic signed [15:0] nx;
		logic signed [15:0] ny;
		logic signed [15:0] nz;
	} vtx_bundle_t;

	// segment count as used: zero acts as one, large values saturate
	function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] cnt,
		input int unsigned max_seg);
		logic [CNT_W-1:0] res;
		res = cnt;
		if (cnt == '0)
			res = CNT_W'(1);
		else if (int'(cnt) > int'(max_seg))
			res = CNT_W'(max_seg);
		return res;
	endfunction

	// Horner coefficients after the degree-9 term
	function automatic logic signed [31:0] horner_coef(input logic [1:0] step);
		logic signed [31:0] c;
		case (step)
			2'd0: c = SIN_C7;
			2'd1: c = SIN_C5;
			2'd2: c = SIN_C3;
			default: c = SIN_C1;
		endcase
		return c;
	endfunction

endpackage
`default_nettype wire

>>> src/csvg_front.sv
// Front end: takes commands, drops out-of-range segments, queues the rest.
`default_nettype none
module csvg_front #(
	parameter int unsigned MAX_SEGMENTS = csvg_pkg::MAX_SEGMENTS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire logic [csvg_pkg::IDX_W-1:0] segment_index,
	input  wire logic [csvg_pkg::CNT_W-1:0] segment_count,
	output logic busy,
	input  wire logic pop,
	output logic q_valid,
	output logic [csvg_pkg::IDX_W-1:0] q_index
);
	localparam int unsigned PTR_W = $clog2(csvg_pkg::QDEPTH);
	localparam int unsigned CNTQ_W = $clog2(csvg_pkg::QDEPTH + 1);

	logic [csvg_pkg::IDX_W-1:0] mem_q [csvg_pkg::QDEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNTQ_W-1:0] fill_q;
	logic [csvg_pkg::CNT_W-1:0] n_eff;
	logic push, do_pop;

	assign n_eff   = csvg_pkg::eff_count(segment_count, MAX_SEGMENTS);
	assign busy    = (fill_q == CNTQ_W'(csvg_pkg::QDEPTH));
	assign push    = start && !busy && ({1'b0, segment_index} < n_eff);
	assign q_valid = (fill_q != '0);
	assign q_index = mem_q[rd_ptr_q];
	assign do_pop  = pop && q_valid;

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= segment_index;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(csvg_pkg::QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(csvg_pkg::QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !do_pop)
				fill_q <= fill_q + 1'b1;
			else if (!push && do_pop)
				fill_q <= fill_q - 1'b1;
		end
	end
endmodule
`default_nettype wire

>>> src/csvg_div.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module csvg_div (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire logic [csvg_pkg::DVD_W-1:0] dividend,
	input  wire logic [csvg_pkg::DVS_W-1:0] divisor,
	output logic done,
	output logic [csvg_pkg::DVD_W-1:0] quotient
);
	localparam int unsigned DVD_W = csvg_pkg::DVD_W;
	localparam int unsigned DVS_W = csvg_pkg::DVS_W;
	localparam int unsigned STEP_W = $clog2(DVD_W);

	logic [DVD_W-1:0] quo_q;
	logic [DVS_W-1:0] rem_q, den_q;
	logic [STEP_W-1:0] step_q;
	logic run_q, done_q;
	logic [DVS_W:0] trial;
	logic ge;

	assign trial    = {rem_q, quo_q[DVD_W-1]};
	assign ge       = (trial >= {1'b0, den_q});
	assign done     = done_q;
	assign quotient = quo_q;

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (run_q) begin
			rem_q <= ge ? DVS_W'(trial - {1'b0, den_q}) : trial[DVS_W-1:0];
			quo_q <= {quo_q[DVD_W-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q  <= 1'b1;
				step_q <= '0;
			end else if (run_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(DVD_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end
endmodule
`default_nettype wire

>>> src/csvg_back.sv
// Back end: angles, sine/cosine, slope and normal through a shared multiplier and divider.
`default_nettype none
module csvg_back #(
	parameter int unsigned MAX_SEGMENTS = csvg_pkg::MAX_SEGMENTS_DEF,
	parameter int unsigned ANGLE_BITS   = csvg_pkg::ANGLE_BITS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic q_valid,
	input  wire logic [csvg_pkg::IDX_W-1:0] q_index,
	output logic pop,
	input  wire logic [csvg_pkg::CNT_W-1:0] segment_count,
	input  wire logic [14:0] cone_height,
	input  wire logic signed [15:0] bottom_radius,
	input  wire logic signed [15:0] top_radius,
	input  wire logic [15:0] angle_offset,
	input  wire logic flip_normals,
	input  wire logic emit_ready,
	output logic emit_load,
	output csvg_pkg::vtx_bundle_t bundle
);
	localparam int unsigned AB    = ANGLE_BITS;
	localparam int unsigned IDX_W = csvg_pkg::IDX_W;
	localparam int unsigned DVD_W = csvg_pkg::DVD_W;
	localparam int unsigned DVS_W = csvg_pkg::DVS_W;
	localparam int unsigned SQ_W  = csvg_pkg::SQ_W;

	csvg_pkg::back_state_t state_q, state_nxt;
	csvg_pkg::div_op_t div_sel_q;

	logic [IDX_W-1:0] r_q;
	logic [AB-1:0] qa0_q, qa1_q, qah_q;
	logic signed [31:0] slope_q;
	logic signed [15:0] trig_q [6];
	logic signed [15:0] nx_q, ny_q, nz_q;
	logic [2:0] k_q;
	logic [1:0] hstep_q, sq_idx_q, quad_q;
	logic [16:0] x_q, x2_q;
	logic signed [31:0] p_q;
	logic signed [63:0] prod_q;
	logic [SQ_W-1:0] acc_q, v_q, root_q, bit_q;
	logic [DVS_W-1:0] len_q;

	// divider
	logic div_start, div_done;
	logic [DVD_W-1:0] dvd, div_quo;
	logic [DVS_W-1:0] dvs;

	csvg_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(dvd),
		.divisor(dvs), .done(div_done), .quotient(div_quo)
	);

	// segment and angle helpers
	logic [csvg_pkg::CNT_W-1:0] n_eff;
	logic [IDX_W:0] r_inc;
	logic [IDX_W-1:0] r1;
	logic [AB+15:0] off_full;
	logic [AB-1:0] off, ang_base, ang_sum;
	logic [31:0] a32;
	logic [30:0] fm;
	logic [14:0] hgt;

	assign n_eff    = csvg_pkg::eff_count(segment_count, MAX_SEGMENTS);
	assign r_inc    = {1'b0, r_q} + 1'b1;
	assign r1       = (r_inc == n_eff) ? '0 : r_inc[IDX_W-1:0];
	assign off_full = ((AB + 16)'(angle_offset) << AB) >> 16;
	assign off      = off_full[AB-1:0];
	assign hgt      = (cone_height == '0) ? 15'd1 : cone_height;

	always_comb begin
		case (k_q[2:1])
			2'd0: ang_base = qa0_q;
			2'd1: ang_base = qa1_q;
			default: ang_base = qah_q;
		endcase
		ang_sum = ang_base + off;
		a32 = 32'(ang_sum) << (32 - AB);
		if (!k_q[0])
			a32 = a32 + 32'h4000_0000;   // cosine is sine a quarter turn on
		fm = a32[30] ? (31'h4000_0000 - {1'b0, a32[29:0]}) : {1'b0, a32[29:0]};
	end

	// magnitudes feeding the divider
	logic [32:0] sprod_mag;
	logic signed [31:0] uval;
	logic [30:0] umag;

	always_comb begin
		sprod_mag = prod_q[63] ? 33'(-prod_q) : prod_q[32:0];
		case (div_sel_q)
			csvg_pkg::DIV_NX: uval = 32'(trig_q[4]);
			csvg_pkg::DIV_NZ: uval = 32'(trig_q[5]);
			default: uval = slope_q;
		endcase
		umag = uval[31] ? 31'(-uval) : uval[30:0];
		dvd = '0;
		dvs = DVS_W'(n_eff);
		case (div_sel_q)
			csvg_pkg::DIV_A0: dvd = DVD_W'(r_q) << AB;
			csvg_pkg::DIV_A1: dvd = DVD_W'(r1) << AB;
			csvg_pkg::DIV_AH: dvd = DVD_W'({r_q, 1'b1}) << (AB - 1);
			csvg_pkg::DIV_SLOPE: begin
				dvd = DVD_W'(sprod_mag) << 6;
				dvs = DVS_W'(hgt);
			end
			csvg_pkg::DIV_NX, csvg_pkg::DIV_NY, csvg_pkg::DIV_NZ: begin
				dvd = (DVD_W'(umag) << 14) + DVD_W'(len_q[DVS_W-1:1]);
				dvs = len_q;
			end
			default: ;
		endcase
	end

	// shared multiplier
	logic signed [31:0] mul_a, mul_b, sqv;
	logic mul_en;

	always_comb begin
		case (sq_idx_q)
			2'd0: sqv = 32'(trig_q[4]);
			2'd1: sqv = 32'(trig_q[5]);
			default: sqv = slope_q;
		endcase
		mul_en = 1'b1;
		mul_a  = '0;
		mul_b  = '0;
		case (state_q)
			csvg_pkg::BS_SPROD: begin
				mul_a = 32'(bottom_radius) - 32'(top_radius);
				mul_b = 32'(bottom_radius);
			end
			csvg_pkg::BS_TSQ: begin
				mul_a = 32'(fm[30:14]);
				mul_b = 32'(fm[30:14]);
			end
			csvg_pkg::BS_THMUL: begin
				mul_a = p_q;
				mul_b = 32'(x2_q);
			end
			csvg_pkg::BS_TFMUL: begin
				mul_a = p_q;
				mul_b = 32'(x_q);
			end
			csvg_pkg::BS_SQMUL: begin
				mul_a = sqv;
				mul_b = sqv;
			end
			default: mul_en = 1'b0;
		endcase
	end

	// datapath helpers
	logic signed [63:0] rnd;
	logic [33:0] s_raw;
	logic signed [15:0] s_fin;
	logic [SQ_W-1:0] acc_nxt, sq_t, root_nxt;
	logic sq_ge;
	logic [DVD_W-1:0] slope_mag, unit_mag;
	logic [15:0] unit_res;
	logic unit_neg;

	always_comb begin
		rnd   = prod_q + 64'sd536870912;
		s_raw = rnd[63:30];
		if (rnd[63])
			s_fin = '0;
		else if (s_raw > 34'd16384)
			s_fin = 16'sd16384;
		else
			s_fin = 16'(s_raw);
		if (quad_q[1])
			s_fin = -s_fin;
		acc_nxt   = acc_q + prod_q[SQ_W-1:0];
		sq_t      = root_q + bit_q;
		sq_ge     = (v_q >= sq_t);
		root_nxt  = sq_ge ? ((root_q >> 1) + bit_q) : (root_q >> 1);
		slope_mag = (div_quo > csvg_pkg::SLOPE_LIMIT) ? csvg_pkg::SLOPE_LIMIT : div_quo;
		unit_mag  = (div_quo > csvg_pkg::UNIT_ONE) ? csvg_pkg::UNIT_ONE : div_quo;
		unit_neg  = uval[31] ^ flip_normals;
		unit_res  = unit_neg ? 16'(-unit_mag[15:0]) : unit_mag[15:0];
	end

	// control
	always_comb begin
		state_nxt = state_q;
		pop       = 1'b0;
		div_start = 1'b0;
		emit_load = 1'b0;
		case (state_q)
			csvg_pkg::BS_IDLE: begin
				if (q_valid) begin
					pop       = 1'b1;
					state_nxt = csvg_pkg::BS_DSTART;
				end
			end
			csvg_pkg::BS_DSTART: begin
				div_start = 1'b1;
				state_nxt = csvg_pkg::BS_DWAIT;
			end
			csvg_pkg::BS_DWAIT: begin
				if (div_done) begin
					case (div_sel_q)
						csvg_pkg::DIV_AH:    state_nxt = csvg_pkg::BS_SPROD;
						csvg_pkg::DIV_SLOPE: state_nxt = csvg_pkg::BS_TSETUP;
						csvg_pkg::DIV_NZ:    state_nxt = csvg_pkg::BS_HAND;
						default:             state_nxt = csvg_pkg::BS_DSTART;
					endcase
				end
			end
			csvg_pkg::BS_SPROD:  state_nxt = csvg_pkg::BS_DSTART;
			csvg_pkg::BS_TSETUP: state_nxt = csvg_pkg::BS_TSQ;
			csvg_pkg::BS_TSQ:    state_nxt = csvg_pkg::BS_TX2;
			csvg_pkg::BS_TX2:    state_nxt = csvg_pkg::BS_THMUL;
			csvg_pkg::BS_THMUL:  state_nxt = csvg_pkg::BS_THADD;
			csvg_pkg::BS_THADD:
				state_nxt = (hstep_q == 2'd3) ? csvg_pkg::BS_TFMUL : csvg_pkg::BS_THMUL;
			csvg_pkg::BS_TFMUL:  state_nxt = csvg_pkg::BS_TFIN;
			csvg_pkg::BS_TFIN:
				state_nxt = (k_q == 3'd5) ? csvg_pkg::BS_SQMUL : csvg_pkg::BS_TSETUP;
			csvg_pkg::BS_SQMUL:  state_nxt = csvg_pkg::BS_SQACC;
			csvg_pkg::BS_SQACC:
				state_nxt = (sq_idx_q == 2'd2) ? csvg_pkg::BS_SQRT : csvg_pkg::BS_SQMUL;
			csvg_pkg::BS_SQRT:
				if (bit_q[0])
					state_nxt = csvg_pkg::BS_DSTART;
			csvg_pkg::BS_HAND: begin
				if (emit_ready) begin
					emit_load = 1'b1;
					state_nxt = csvg_pkg::BS_IDLE;
				end
			end
			default: state_nxt = csvg_pkg::BS_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= csvg_pkg::BS_IDLE;
		else
			state_q <= state_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			div_sel_q <= csvg_pkg::DIV_A0;
		else if (state_q == csvg_pkg::BS_IDLE && q_valid)
			div_sel_q <= csvg_pkg::DIV_A0;
		else if (state_q == csvg_pkg::BS_DWAIT && div_done) begin
			case (div_sel_q)
				csvg_pkg::DIV_A0: div_sel_q <= csvg_pkg::DIV_A1;
				csvg_pkg::DIV_A1: div_sel_q <= csvg_pkg::DIV_AH;
				csvg_pkg::DIV_AH: div_sel_q <= csvg_pkg::DIV_SLOPE;
				csvg_pkg::DIV_NX: div_sel_q <= csvg_pkg::DIV_NY;
				csvg_pkg::DIV_NY: div_sel_q <= csvg_pkg::DIV_NZ;
				default: ;
			endcase
		end else if (state_q == csvg_pkg::BS_SQRT && bit_q[0])
			div_sel_q <= csvg_pkg::DIV_NX;
	end

	always_ff @(posedge clk) begin
		if (mul_en)
			prod_q <= mul_a * mul_b;
		case (state_q)
			csvg_pkg::BS_IDLE: begin
				r_q <= q_index;
				k_q <= '0;
			end
			csvg_pkg::BS_DWAIT: begin
				if (div_done) begin
					case (div_sel_q)
						csvg_pkg::DIV_A0: qa0_q <= div_quo[AB-1:0];
						csvg_pkg::DIV_A1: qa1_q <= div_quo[AB-1:0];
						csvg_pkg::DIV_AH: qah_q <= div_quo[AB-1:0];
						csvg_pkg::DIV_SLOPE:
							slope_q <= prod_q[63] ? -32'(slope_mag) : 32'(slope_mag);
						csvg_pkg::DIV_NX: nx_q <= unit_res;
						csvg_pkg::DIV_NY: ny_q <= unit_res;
						csvg_pkg::DIV_NZ: nz_q <= unit_res;
						default: ;
					endcase
				end
			end
			csvg_pkg::BS_TSETUP: begin
				x_q    <= fm[30:14];
				quad_q <= a32[31:30];
			end
			csvg_pkg::BS_TX2: begin
				x2_q    <= prod_q[32:16];
				p_q     <= csvg_pkg::SIN_C9;
				hstep_q <= '0;
			end
			csvg_pkg::BS_THADD: begin
				p_q     <= csvg_pkg::horner_coef(hstep_q) + prod_q[47:16];
				hstep_q <= hstep_q + 1'b1;
			end
			csvg_pkg::BS_TFIN: begin
				trig_q[k_q] <= s_fin;
				k_q         <= k_q + 1'b1;
				acc_q       <= '0;
				sq_idx_q    <= '0;
			end
			csvg_pkg::BS_SQACC: begin
				acc_q    <= acc_nxt;
				sq_idx_q <= sq_idx_q + 1'b1;
				v_q      <= acc_nxt;
				root_q   <= '0;
				bit_q    <= SQ_W'(1) << (SQ_W - 1);
			end
			csvg_pkg::BS_SQRT: begin
				if (sq_ge)
					v_q <= v_q - sq_t;
				root_q <= root_nxt;
				bit_q  <= bit_q >> 2;
				if (bit_q[0])
					len_q <= (root_nxt == '0) ? DVS_W'(1) : root_nxt[DVS_W-1:0];
			end
			default: ;
		endcase
	end

	always_comb begin
		bundle.seg = r_q;
		bundle.c0x = trig_q[0];
		bundle.c0y = trig_q[1];
		bundle.c1x = trig_q[2];
		bundle.c1y = trig_q[3];
		bundle.nx  = nx_q;
		bundle.ny  = ny_q;
		bundle.nz  = nz_q;
	end
endmodule
`default_nettype wire

>>> src/csvg_emit.sv
// Vertex emitter: four corner transactions per segment from a registered bundle.
`default_nettype none
module csvg_emit (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic load,
	input  wire csvg_pkg::vtx_bundle_t bundle,
	input  wire logic [14:0] cone_height,
	input  wire logic signed [15:0] bottom_radius,
	input  wire logic signed [15:0] top_radius,
	output logic ready,
	output logic vertex_valid,
	output logic [csvg_pkg::VIDX_W-1:0] vertex_index,
	output logic signed [15:0] pos_x,
	output logic signed [15:0] pos_y,
	output logic signed [15:0] pos_z,
	output logic signed [15:0] norm_x,
	output logic signed [15:0] norm_y,
	output logic signed [15:0] norm_z,
	output logic signed [15:0] tex_u,
	output logic [14:0] tex_v,
	output logic signed [15:0] tex_w,
	output logic last_vertex
);
	csvg_pkg::vtx_bundle_t bnd_q;
	logic [1:0] k_q;
	logic act_q;

	function automatic logic signed [15:0] ring_pos(input logic signed [15:0] c,
		input logic signed [15:0] rad);
		logic signed [31:0] m;
		logic signed [32:0] r;
		logic signed [18:0] s;
		logic signed [15:0] o;
		m = c * rad;
		r = 33'(m) + 33'sd8192;
		s = 19'(r >>> 14);
		if (s > 19'sd32767)
			o = 16'sd32767;
		else if (s < -19'sd32768)
			o = -16'sd32768;
		else
			o = 16'(s);
		return o;
	endfunction

	logic top, second;
	logic signed [15:0] cx, cy, rad;

	assign ready  = !act_q || (k_q == 2'd3);
	assign top    = k_q[0];
	assign second = k_q[1];
	assign cx     = second ? bnd_q.c1x : bnd_q.c0x;
	assign cy     = second ? bnd_q.c1y : bnd_q.c0y;
	assign rad    = top ? top_radius : bottom_radius;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q        <= 1'b0;
			k_q          <= '0;
			vertex_valid <= 1'b0;
		end else begin
			vertex_valid <= act_q;
			if (load && ready) begin
				act_q <= 1'b1;
				k_q   <= '0;
			end else if (act_q) begin
				k_q <= k_q + 1'b1;
				if (k_q == 2'd3)
					act_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && ready)
			bnd_q <= bundle;
		vertex_index <= {bnd_q.seg, k_q};
		pos_x        <= ring_pos(cx, rad);
		pos_y        <= top ? 16'(cone_height) : '0;
		pos_z        <= ring_pos(cy, rad);
		norm_x       <= bnd_q.nx;
		norm_y       <= bnd_q.ny;
		norm_z       <= bnd_q.nz;
		tex_u        <= cx;
		tex_v        <= top ? 15'd16384 : '0;
		tex_w        <= cy;
		last_vertex  <= (k_q == 2'd3);
	end
endmodule
`default_nettype wire

>>> src/cone_segment_vertex_generator_top.sv
// Top level of the cone segment vertex generator: config registers, front, back, emitter.
`default_nettype none
// A segment command is taken when start is high and busy is low; segments at or beyond the
// segment count are dropped. Each kept segment yields four vertex transactions back to back,
// each marked by vertex_valid for one cycle; the receiver cannot stall them. The back end
// computes each segment with seven 48-step serial divisions (three angles, slope, three
// normal components) on one shared divider, plus the polynomial sine/cosine and a 31-step
// square root. Up to two segments wait in the queue, and the next segment is computed while
// the previous one's vertices are sent.
// Configuration is written through cfg_valid/cfg_ready, which is always ready.
module cone_segment_vertex_generator_top #(
	parameter int unsigned MAX_SEGMENTS = csvg_pkg::MAX_SEGMENTS_DEF,
	parameter int unsigned ANGLE_BITS   = csvg_pkg::ANGLE_BITS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	output logic busy,
	input  wire logic [11:0] segment_index,
	input  wire logic cfg_valid,
	output logic cfg_ready,
	input  wire logic [csvg_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [csvg_pkg::CFG_DAT_W-1:0] cfg_data,
	output logic vertex_valid,
	output logic [13:0] vertex_index,
	output logic signed [15:0] pos_x,
	output logic signed [15:0] pos_y,
	output logic signed [15:0] pos_z,
	output logic signed [15:0] norm_x,
	output logic signed [15:0] norm_y,
	output logic signed [15:0] norm_z,
	output logic signed [15:0] tex_u,
	output logic [14:0] tex_v,
	output logic signed [15:0] tex_w,
	output logic last_vertex
);
	logic [12:0] segment_count_q;
	logic [14:0] cone_height_q;
	logic signed [15:0] bottom_radius_q, top_radius_q;
	logic [15:0] angle_offset_q;
	logic flip_normals_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			segment_count_q <= 13'd32;
			cone_height_q   <= 15'd256;
			bottom_radius_q <= 16'sd256;
			top_radius_q    <= '0;
			angle_offset_q  <= '0;
			flip_normals_q  <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				csvg_pkg::CFG_SEGMENT_COUNT: segment_count_q <= cfg_data[12:0];
				csvg_pkg::CFG_CONE_HEIGHT:   cone_height_q   <= cfg_data[14:0];
				csvg_pkg::CFG_BOTTOM_RADIUS: bottom_radius_q <= cfg_data;
				csvg_pkg::CFG_TOP_RADIUS:    top_radius_q    <= cfg_data;
				csvg_pkg::CFG_ANGLE_OFFSET:  angle_offset_q  <= cfg_data;
				csvg_pkg::CFG_FLIP_NORMALS:  flip_normals_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	logic q_valid, pop, emit_ready, emit_load;
	logic [11:0] q_index;
	csvg_pkg::vtx_bundle_t bundle;

	csvg_front #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_front (
		.clk(clk), .arst_n(arst_n), .start(start), .segment_index(segment_index),
		.segment_count(segment_count_q), .busy(busy), .pop(pop),
		.q_valid(q_valid), .q_index(q_index)
	);

	csvg_back #(.MAX_SEGMENTS(MAX_SEGMENTS), .ANGLE_BITS(ANGLE_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_index(q_index), .pop(pop),
		.segment_count(segment_count_q), .cone_height(cone_height_q),
		.bottom_radius(bottom_radius_q), .top_radius(top_radius_q),
		.angle_offset(angle_offset_q), .flip_normals(flip_normals_q),
		.emit_ready(emit_ready), .emit_load(emit_load), .bundle(bundle)
	);

	csvg_emit u_emit (
		.clk(clk), .arst_n(arst_n), .load(emit_load), .bundle(bundle),
		.cone_height(cone_height_q), .bottom_radius(bottom_radius_q),
		.top_radius(top_radius_q), .ready(emit_ready), .vertex_valid(vertex_valid),
		.vertex_index(vertex_index), .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
		.norm_x(norm_x), .norm_y(norm_y), .norm_z(norm_z), .tex_u(tex_u),
		.tex_v(tex_v), .tex_w(tex_w), .last_vertex(last_vertex)
	);

	// a segment's four vertices go out back to back
	a_burst: assert property (@(posedge clk) disable iff (!arst_n)
		vertex_valid && !last_vertex |=> vertex_valid)
		else $error("vertex burst broken");

	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		vertex_valid && !last_vertex |=> vertex_index == $past(vertex_index) + 14'd1)
		else $error("vertex index out of order");

	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		vertex_valid && last_vertex |-> vertex_index[1:0] == 2'd3 && tex_v != '0)
		else $error("last vertex is not the top corner of the second edge");
endmodule
`default_nettype wire
